// ----- src/brfb_pkg.sv -----
// brfb_pkg: shared types and codes for the byte ring buffer.
// Used by brfb_ctrl, brfb_dp and byte_ring_fifo_burst. No dependencies.

package brfb_pkg;

	typedef logic [1:0] opcode_t;
	typedef logic [2:0] kind_t;
	typedef logic [1:0] bstate_t;

	localparam opcode_t OP_WRITE = 2'd0;
	localparam opcode_t OP_READ  = 2'd1;
	localparam opcode_t OP_TICK  = 2'd2;

	localparam kind_t K_REJECT  = 3'd0;
	localparam kind_t K_DATA    = 3'd1;
	localparam kind_t K_INVALID = 3'd2;
	localparam kind_t K_TIMEOUT = 3'd3;
	localparam kind_t K_BUSY    = 3'd4;
	localparam kind_t K_EMPTY   = 3'd5;

	localparam bstate_t BS_IDLE   = 2'd0;
	localparam bstate_t BS_ACCEPT = 2'd1;
	localparam bstate_t BS_REJECT = 2'd2;

	localparam logic [15:0] TIMEOUT_RESET = 16'd15;

	typedef struct packed {
		logic  wr;
		logic  res;
		kind_t res_kind;
		logic  head_chk;
		logic  emit_start;
		logic  emit_src_pend;
		logic  emit_step;
		logic  pend_set;
		logic  tick;
	} cmd_t;

	typedef struct packed {
		logic reject;
		logic commit;
		logic len_invalid;
		logic len_zero;
		logic len_le_count;
		logic pend_valid;
		logic pend_ok;
		logic tmo_hit;
		logic emit_last;
	} stat_t;

endpackage

// ----- src/brfb_ctrl.sv -----
// brfb_ctrl: controller state machine, decodes transactions into datapath commands.
// Depends on brfb_pkg.

module brfb_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  brfb_pkg::opcode_t opcode,
	input  logic             first,
	input  logic             final_req,
	input  brfb_pkg::stat_t  stat,
	output brfb_pkg::cmd_t   cmd,
	output logic             busy
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SERVE = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					unique case (opcode)
						brfb_pkg::OP_WRITE: begin
							cmd.wr = 1'b1;
							if (first && stat.reject) begin
								cmd.res      = 1'b1;
								cmd.res_kind = brfb_pkg::K_REJECT;
							end
							if (final_req && stat.commit)
								state_d = ST_SERVE;
						end
						brfb_pkg::OP_READ: begin
							priority if (stat.len_invalid) begin
								cmd.res      = 1'b1;
								cmd.res_kind = brfb_pkg::K_INVALID;
							end else if (stat.pend_valid) begin
								cmd.res      = 1'b1;
								cmd.res_kind = brfb_pkg::K_BUSY;
							end else if (stat.len_zero) begin
								cmd.res      = 1'b1;
								cmd.res_kind = brfb_pkg::K_EMPTY;
								cmd.head_chk = 1'b1;
							end else if (stat.len_le_count) begin
								cmd.emit_start = 1'b1;
								state_d        = ST_EMIT;
							end else begin
								cmd.pend_set = 1'b1;
							end
						end
						brfb_pkg::OP_TICK: begin
							if (stat.pend_valid) begin
								cmd.tick = 1'b1;
								if (stat.tmo_hit) begin
									cmd.res      = 1'b1;
									cmd.res_kind = brfb_pkg::K_TIMEOUT;
								end
							end
						end
						default: ;
					endcase
				end
			end
			ST_SERVE: begin
				if (stat.pend_valid && stat.pend_ok) begin
					cmd.emit_start    = 1'b1;
					cmd.emit_src_pend = 1'b1;
					state_d           = ST_EMIT;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_EMIT: begin
				cmd.emit_step = 1'b1;
				if (stat.emit_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

// ----- src/brfb_dp.sv -----
// brfb_dp: datapath with byte store, ring pointers, burst and pending-read state,
// timeout timer and result registers. Depends on brfb_pkg.

module brfb_dp #(
	parameter int CAPACITY = 4096,
	parameter int READ_MAX = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  brfb_pkg::cmd_t  cmd,
	output brfb_pkg::stat_t stat,
	input  logic [7:0]      wr_byte,
	input  logic [12:0]     length,
	input  logic            first,
	input  logic            final_req,
	input  logic            cfg_valid,
	input  logic [15:0]     cfg_data,
	output logic            strobe,
	output brfb_pkg::kind_t kind,
	output logic [7:0]      rd_byte,
	output logic            last_of_run
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = $clog2(READ_MAX + 1);
	localparam int SW = CW + 1;
	localparam int LW = ((CW > 13) ? CW : 13) + 1;
	localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
	localparam logic [AW-1:0] PTR_LAST = AW'(CAPACITY - 1);

	function automatic logic [AW-1:0] wrap(input logic [SW-1:0] x);
		logic [SW-1:0] r;
		r = (x >= CAP_S) ? (x - CAP_S) : x;
		return r[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] inc_ptr(input logic [AW-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	logic [7:0]    mem [CAPACITY];
	logic [AW-1:0] head_q, wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q, blen_q, boff_q;
	brfb_pkg::bstate_t bs_q;
	logic          pend_q;
	logic [PW-1:0] pend_len_q, emit_i_q, emit_n_q;
	logic [15:0]   timer_q, timeout_q;
	logic          strobe_q, last_q, dsel_q;
	brfb_pkg::kind_t kind_q;
	logic [7:0]    mem_q;

	logic              fits, open_acc, open_rej, do_store;
	brfb_pkg::bstate_t bs_eff;
	logic [CW-1:0]     blen_eff, off_eff, off_new, cnt_after;
	logic [AW-1:0]     base, ptr_eff, head_after;
	logic [PW-1:0]     rd_len;
	logic [15:0]       timer_inc;

	always_comb begin
		fits     = (LW'(count_q) + LW'(length)) <= LW'(CAPACITY);
		open_acc = first && fits;
		open_rej = first && !fits;
		base     = wrap(SW'(head_q) + SW'(count_q));
		priority if (open_acc)
			bs_eff = brfb_pkg::BS_ACCEPT;
		else if (open_rej)
			bs_eff = brfb_pkg::BS_REJECT;
		else
			bs_eff = bs_q;
		blen_eff = open_acc ? CW'(length) : blen_q;
		off_eff  = open_acc ? '0 : boff_q;
		ptr_eff  = open_acc ? base : wr_ptr_q;
		do_store = (bs_eff == brfb_pkg::BS_ACCEPT) && (off_eff < blen_eff);
		off_new  = off_eff + CW'(do_store);

		timer_inc = (timer_q == 16'hFFFF) ? timer_q : timer_q + 16'd1;

		stat.reject       = open_rej;
		stat.commit       = final_req && (bs_eff == brfb_pkg::BS_ACCEPT);
		stat.len_invalid  = (LW'(length) > LW'(CAPACITY)) || (LW'(length) > LW'(READ_MAX));
		stat.len_zero     = (length == 13'd0);
		stat.len_le_count = LW'(length) <= LW'(count_q);
		stat.pend_valid   = pend_q;
		stat.pend_ok      = CW'(pend_len_q) <= count_q;
		stat.tmo_hit      = timer_inc >= timeout_q;
		stat.emit_last    = (emit_i_q == emit_n_q - 1'b1);
	end

	always_comb begin
		rd_len     = cmd.emit_src_pend ? pend_len_q : length[PW-1:0];
		cnt_after  = count_q - CW'(rd_len);
		head_after = (cnt_after == '0 && bs_q != brfb_pkg::BS_ACCEPT)
			? '0 : wrap(SW'(head_q) + SW'(rd_len));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			count_q    <= '0;
			blen_q     <= '0;
			boff_q     <= '0;
			bs_q       <= brfb_pkg::BS_IDLE;
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			pend_q     <= 1'b0;
			pend_len_q <= '0;
			emit_i_q   <= '0;
			emit_n_q   <= '0;
			timer_q    <= '0;
			timeout_q  <= brfb_pkg::TIMEOUT_RESET;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= cmd.res || cmd.emit_step;
			if (cfg_valid)
				timeout_q <= cfg_data;

			if (cmd.wr) begin
				bs_q     <= final_req ? brfb_pkg::BS_IDLE : bs_eff;
				wr_ptr_q <= do_store ? inc_ptr(ptr_eff) : ptr_eff;
				if (open_acc)
					blen_q <= blen_eff;
				if (stat.commit) begin
					boff_q  <= '0;
					count_q <= count_q + off_new;
				end else begin
					boff_q <= off_new;
				end
			end

			if (cmd.head_chk && count_q == '0 && bs_q != brfb_pkg::BS_ACCEPT)
				head_q <= '0;

			if (cmd.emit_start) begin
				rd_ptr_q <= head_q;
				emit_n_q <= rd_len;
				emit_i_q <= '0;
				count_q  <= cnt_after;
				head_q   <= head_after;
				pend_q   <= 1'b0;
				timer_q  <= '0;
			end

			if (cmd.emit_step) begin
				rd_ptr_q <= inc_ptr(rd_ptr_q);
				emit_i_q <= emit_i_q + 1'b1;
			end

			if (cmd.pend_set) begin
				pend_q     <= 1'b1;
				pend_len_q <= length[PW-1:0];
				timer_q    <= '0;
			end

			if (cmd.tick) begin
				if (stat.tmo_hit) begin
					pend_q     <= 1'b0;
					pend_len_q <= '0;
					timer_q    <= '0;
				end else begin
					timer_q <= timer_inc;
				end
			end
		end
	end

	// store and result payload, no reset
	always_ff @(posedge clk) begin
		if (cmd.wr && do_store)
			mem[ptr_eff] <= wr_byte;
		if (cmd.emit_step)
			mem_q <= mem[rd_ptr_q];
		kind_q <= cmd.emit_step ? brfb_pkg::K_DATA : cmd.res_kind;
		last_q <= cmd.emit_step ? stat.emit_last : 1'b1;
		dsel_q <= cmd.emit_step;
	end

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign rd_byte     = dsel_q ? mem_q : 8'd0;
	assign last_of_run = last_q;

endmodule

// ----- src/byte_ring_fifo_burst.sv -----
// byte_ring_fifo_burst: top level, byte ring buffer with burst writes and blocking reads.
// Depends on brfb_pkg, brfb_ctrl, brfb_dp.
// A single result (reject, invalid, busy, empty, timeout) shows in the cycle after start.
// Read data: n bytes at one per cycle while in the emit state, which holds busy.
// Other items leave busy low; a write closing an accepted burst is busy in the serve state,
// and in emit if it serves a waiting read. No result stall; reset clears all control state.

module byte_ring_fifo_burst #(
	parameter int CAPACITY = 4096,
	parameter int READ_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  brfb_pkg::opcode_t opcode,
	input  logic [7:0]       wr_byte,
	input  logic [12:0]      length,
	input  logic             first,
	input  logic             final_req,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [15:0]      cfg_data,
	output logic             strobe,
	output brfb_pkg::kind_t  kind,
	output logic [7:0]       rd_byte,
	output logic             last_of_run
);

	brfb_pkg::cmd_t  cmd;
	brfb_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	brfb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.opcode    (opcode),
		.first     (first),
		.final_req (final_req),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	brfb_dp #(
		.CAPACITY (CAPACITY),
		.READ_MAX (READ_MAX)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.wr_byte     (wr_byte),
		.length      (length),
		.first       (first),
		.final_req   (final_req),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.strobe      (strobe),
		.kind        (kind),
		.rd_byte     (rd_byte),
		.last_of_run (last_of_run)
	);

endmodule
